FILE: hdl/p2ba_pkg.sv
// Shared codes for the power-of-two block allocator.
// Command and status codes used by the top level and the bench.
// No dependencies.
`default_nettype none
package p2ba_pkg;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_MEM  = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  typedef logic [1:0] status_t;
endpackage
`default_nettype wire

FILE: hdl/p2ba_link_store.sv
// Next-link memory of the free lists, one entry per granule.
// Standalone; the read data is registered.
`default_nettype none
module p2ba_link_store #(
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [AW-1:0] rd_data
);
  logic [AW-1:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: hdl/p2ba_order_store.sv
// Per-granule order memory: order of the live block starting there, zero if none.
// Depends on p2ba_pkg. Clears itself with one sweep after reset or on request.
`default_nettype none
module p2ba_order_store #(
  parameter int AW = 10,
  parameter int DW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  output logic               busy
);
  import p2ba_pkg::*;

  logic [DW-1:0] mem [1<<AW];
  logic [AW-1:0] sweep;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      sweep <= sweep + AW'(1);
      if (sweep == {AW{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: hdl/power_of_two_block_allocator.sv
// Top level of the power-of-two block allocator.
// Depends on p2ba_pkg, p2ba_link_store and p2ba_order_store.
//
// Usage: commands enter on the s_ stream (s_tuser is the command, 0 allocate,
// 1 free), one result word per command leaves on the m_ stream. The cfg
// channel writes pool_order; the value is clamped to the legal range and the
// pool is reset to one free block at offset 0. cfg_ready is always high, and
// s_tready stays low while cfg_valid is high.
// Commands are taken one at a time: the next is taken only once the block has
// returned to ST_IDLE. A free passes ST_FREE1, which makes the range and
// alignment checks, and ST_FREE2, which uses the order read from the order
// memory, before ST_DONE; an address that fails the checks goes from ST_FREE1
// to ST_DONE. An allocation steps the order up in ST_WANT while sizing the
// request, skips empty lists in ST_SCAN, pops a block in ST_POP and ST_POPW,
// and splits it in ST_SPLIT until it fits. A request larger than the pool is
// refused in ST_WANT. Reads of the link and order memories are registered.
// At reset and after a cfg write, the order memory is cleared by a sweep over
// all 2^(MAX_POOL_ORDER-MIN_BLOCK_ORDER) granules, during which s_tready stays low.
// A finished result sits in the output register; while the receiver stalls,
// the next command is still accepted and worked on, and it waits for the
// output register only at its very end.
`default_nettype none
module power_of_two_block_allocator #(
  parameter int MAX_POOL_ORDER  = 16,
  parameter int MIN_BLOCK_ORDER = 6,
  parameter int HEADER_BYTES    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // request_size [15:0], address [31:16]
  input  wire logic        s_tuser,  // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,  // payload_offset, status, block_order, free_bytes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  import p2ba_pkg::*;

  localparam int GW = MAX_POOL_ORDER - MIN_BLOCK_ORDER;
  localparam int NG = 1 << GW;
  localparam int NO = GW + 1;
  localparam int LW = $clog2(NO);
  localparam int OW = $clog2(MAX_POOL_ORDER + 2);
  localparam int FT = MAX_POOL_ORDER + 1;
  localparam int POOL_LOW = (MIN_BLOCK_ORDER > 7) ? MIN_BLOCK_ORDER : 7;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WANT  = 4'd1;
  localparam logic [3:0] ST_SCAN  = 4'd2;
  localparam logic [3:0] ST_POP   = 4'd3;
  localparam logic [3:0] ST_POPW  = 4'd4;
  localparam logic [3:0] ST_SPLIT = 4'd5;
  localparam logic [3:0] ST_FREE1 = 4'd6;
  localparam logic [3:0] ST_FREE2 = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]    state;
  logic [OW-1:0] pool_order;
  logic [OW-1:0] want;
  logic [OW-1:0] cur;
  logic [GW-1:0] gran;
  logic [17:0]   need;
  logic [15:0]   addr;
  logic [GW-1:0] head [NO];
  logic [GW:0]   cnt [NO];
  logic [FT-1:0] ftot;
  logic [15:0]   res_pay;
  status_t       res_status;
  logic [4:0]    res_order;

  // Clamp of a written pool order.
  logic [OW-1:0] cfg_order;
  always_comb begin
    if (32'(cfg_data) < POOL_LOW) begin
      cfg_order = OW'(POOL_LOW);
    end else if (32'(cfg_data) > MAX_POOL_ORDER) begin
      cfg_order = OW'(MAX_POOL_ORDER);
    end else begin
      cfg_order = OW'(cfg_data);
    end
  end

  assign cfg_ready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = cfg_valid && cfg_ready;

  // Pool order that reset or a cfg write starts from, and its list index.
  logic [OW-1:0] init_order;
  logic [LW-1:0] li_init;
  assign init_order = rst ? OW'(MAX_POOL_ORDER) : cfg_order;
  assign li_init    = LW'(init_order - OW'(MIN_BLOCK_ORDER));

  // Memory ports.
  logic          link_we;
  logic [GW-1:0] link_waddr;
  logic [GW-1:0] link_wdata;
  logic [GW-1:0] link_raddr;
  logic [GW-1:0] link_rdata;
  logic          ord_we;
  logic [GW-1:0] ord_waddr;
  logic [OW-1:0] ord_wdata;
  logic [GW-1:0] ord_raddr;
  logic [OW-1:0] ord_rdata;
  logic          ord_busy;

  p2ba_link_store #(.AW(GW)) u_link (
    .clk(clk), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
    .rd_addr(link_raddr), .rd_data(link_rdata)
  );

  p2ba_order_store #(.AW(GW), .DW(OW)) u_order (
    .clk(clk), .rst(rst), .clear(cfg_wr), .wr_en(ord_we), .wr_addr(ord_waddr),
    .wr_data(ord_wdata), .rd_addr(ord_raddr), .rd_data(ord_rdata), .busy(ord_busy)
  );

  // A command word is never taken in the cycle that rebuilds the pool.
  assign s_tready = (state == ST_IDLE) && !ord_busy && !cfg_valid;

  // Derived values of the current step.
  logic [OW-1:0] cur_dec;
  logic [LW-1:0] li_cur;
  logic [LW-1:0] li_dec;
  logic [LW-1:0] li_free;
  logic [GW-1:0] split_gran;
  logic [39:0]   start_w;
  logic          free_ok;
  logic [GW-1:0] free_gran;
  logic [31:0]   pay_wide;
  logic          want_small;

  assign cur_dec    = cur - OW'(1);
  assign li_cur     = LW'(cur - OW'(MIN_BLOCK_ORDER));
  assign li_dec     = LW'(cur_dec - OW'(MIN_BLOCK_ORDER));
  assign li_free    = LW'(ord_rdata - OW'(MIN_BLOCK_ORDER));
  assign split_gran = gran + (GW'(1) << (cur_dec - OW'(MIN_BLOCK_ORDER)));
  assign start_w    = 40'(addr) - 40'(HEADER_BYTES);
  assign free_gran  = GW'(start_w >> MIN_BLOCK_ORDER);
  assign pay_wide   = (32'(gran) << MIN_BLOCK_ORDER) + 32'(HEADER_BYTES);
  assign want_small = (32'(want) < 18) && ((18'(1) << want) < need);
  assign free_ok    = (addr != 16'd0) && (40'(addr) >= 40'(HEADER_BYTES)) &&
                      (start_w[MIN_BLOCK_ORDER-1:0] == '0) &&
                      (start_w < (40'(1) << pool_order)) &&
                      ((start_w >> MIN_BLOCK_ORDER) < 40'(NG));

  // Memory accesses are decided by the state and the values of the current step.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = split_gran;
    link_wdata = head[li_dec];
    link_raddr = head[li_cur];
    ord_we     = 1'b0;
    ord_waddr  = gran;
    ord_wdata  = want;
    ord_raddr  = free_gran;
    unique case (state)
      ST_SPLIT: begin
        if (cur > want) begin
          link_we = 1'b1;
        end else begin
          ord_we = 1'b1;
        end
      end
      ST_FREE2: begin
        if (ord_rdata != '0) begin
          link_we    = 1'b1;
          link_waddr = gran;
          link_wdata = head[li_free];
          ord_we     = 1'b1;
          ord_wdata  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      pool_order <= init_order;
      ftot       <= FT'(1) << init_order;
      // Only the list of the pool order holds a block, the whole pool at offset 0.
      for (int i = 0; i < NO; i++) begin
        head[i] <= '0;
        if (LW'(i) == li_init) begin
          cnt[i] <= (GW+1)'(1);
        end else begin
          cnt[i] <= '0;
        end
      end
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            need  <= 18'(s_tdata[15:0]) + 18'(HEADER_BYTES);
            addr  <= s_tdata[31:16];
            want  <= OW'(MIN_BLOCK_ORDER);
            state <= (s_tuser == CMD_FREE) ? ST_FREE1 : ST_WANT;
          end
        end
        ST_WANT: begin
          if ((32'(want) <= MAX_POOL_ORDER) && want_small) begin
            want <= want + OW'(1);
          end else if (want > pool_order) begin
            res_pay    <= '0;
            res_status <= STATUS_NO_MEM;
            res_order  <= '0;
            state      <= ST_DONE;
          end else begin
            cur   <= want;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cur > pool_order) begin
            res_pay    <= '0;
            res_status <= STATUS_NO_MEM;
            res_order  <= '0;
            state      <= ST_DONE;
          end else if (cnt[li_cur] == '0) begin
            cur <= cur + OW'(1);
          end else begin
            gran  <= head[li_cur];
            state <= ST_POP;
          end
        end
        ST_POP: begin
          // The link read of the popped block is under way.
          state <= ST_POPW;
        end
        ST_POPW: begin
          head[li_cur] <= link_rdata;
          cnt[li_cur]  <= cnt[li_cur] - (GW+1)'(1);
          state        <= ST_SPLIT;
        end
        ST_SPLIT: begin
          if (cur > want) begin
            head[li_dec] <= split_gran;
            cnt[li_dec]  <= cnt[li_dec] + (GW+1)'(1);
            cur          <= cur_dec;
          end else begin
            ftot       <= ftot - (FT'(1) << want);
            res_pay    <= 16'(pay_wide);
            res_status <= STATUS_OK;
            res_order  <= 5'(want);
            state      <= ST_DONE;
          end
        end
        ST_FREE1: begin
          // The order memory is read at free_gran during this cycle.
          gran <= free_gran;
          if (free_ok) begin
            state <= ST_FREE2;
          end else begin
            res_pay    <= '0;
            res_status <= STATUS_BAD_FREE;
            res_order  <= '0;
            state      <= ST_DONE;
          end
        end
        ST_FREE2: begin
          res_pay <= '0;
          if (ord_rdata == '0) begin
            res_status <= STATUS_BAD_FREE;
            res_order  <= '0;
          end else begin
            head[li_free] <= gran;
            cnt[li_free]  <= cnt[li_free] + (GW+1)'(1);
            ftot          <= ftot + (FT'(1) << ord_rdata);
            res_status    <= STATUS_OK;
            res_order     <= 5'(ord_rdata);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register; loaded when a result is finished and the register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {17'(ftot), res_order, res_status, res_pay};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: bench/p2ba_checker.sv
// Checker for the power-of-two block allocator: watches the command, result and
// pool_order channels, keeps its own model of the free lists and compares each result word.
// Depends on p2ba_pkg.
`timescale 1ns / 1ps
module p2ba_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,  // request_size [15:0], address [31:16]
  input  wire logic        s_tuser,  // command
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,  // payload_offset, status, block_order, free_bytes
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [4:0]  cfg_data,
  output int               fail_count,
  output int               pending
);
  import p2ba_pkg::*;

  localparam int MAX_ORD = 16;
  localparam int MIN_ORD = 6;
  localparam int HDR     = 16;
  localparam int NGRAN   = 1 << (MAX_ORD - MIN_ORD);

  typedef struct packed {
    logic [16:0] free_bytes;
    logic [4:0]  block_order;
    status_t     status;
    logic [15:0] payload_offset;
  } alloc_word_t;

  alloc_word_t expected_words[$];

  logic [9:0] head_gran [MIN_ORD:MAX_ORD];
  int         blk_count [MIN_ORD:MAX_ORD];
  logic [9:0] link_gran [NGRAN];
  logic [4:0] live_order[NGRAN];
  int         free_sum;
  int         pool_log;

  task automatic reset_pool();
    for (int o = MIN_ORD; o <= MAX_ORD; o++) begin
      head_gran[o] = '0;
      blk_count[o] = 0;
    end
    for (int g = 0; g < NGRAN; g++) begin
      link_gran[g]  = '0;
      live_order[g] = '0;
    end
    blk_count[pool_log] = 1;
    free_sum = 1 << pool_log;
  endtask

  task automatic push_block(input int ord, input int gran);
    logic [9:0] g;
    g = gran[9:0];
    link_gran[g]   = head_gran[ord];
    head_gran[ord] = g;
    blk_count[ord]++;
  endtask

  task automatic predict_word(input logic cmd, input logic [15:0] size,
                              input logic [15:0] addr);
    alloc_word_t w;
    int need, want, cur, gran, start;
    w = '0;
    if (cmd == CMD_ALLOC) begin
      need = int'(size) + HDR;
      want = MIN_ORD;
      while (want <= MAX_ORD && (1 << want) < need) want++;
      cur = want;
      while (cur <= pool_log && blk_count[cur] == 0) cur++;
      if (want > pool_log || cur > pool_log) begin
        w.status = STATUS_NO_MEM;
      end else begin
        gran = head_gran[cur];
        head_gran[cur] = link_gran[gran];
        blk_count[cur]--;
        // Split down, the upper half of each step goes to the next lower list.
        while (cur > want) begin
          cur--;
          push_block(cur, gran + (1 << (cur - MIN_ORD)));
        end
        live_order[gran] = want[4:0];
        free_sum -= 1 << want;
        w.payload_offset = 16'((gran << MIN_ORD) + HDR);
        w.block_order = want[4:0];
      end
    end else begin
      start = int'(addr) - HDR;
      if (addr != 0 && int'(addr) >= HDR && start[MIN_ORD-1:0] == 0 &&
          start < (1 << pool_log) && live_order[start >> MIN_ORD] != 0) begin
        gran = start >> MIN_ORD;
        w.block_order = live_order[gran];
        live_order[gran] = '0;
        push_block(int'(w.block_order), gran);
        free_sum += 1 << w.block_order;
      end else begin
        w.status = STATUS_BAD_FREE;
      end
    end
    w.free_bytes = free_sum[16:0];
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    alloc_word_t got, exp_w;
    if (rst) begin
      pool_log = MAX_ORD;
      reset_pool();
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            if (got.payload_offset !== exp_w.payload_offset)
              $error("payload_offset expected %0d got %0d", exp_w.payload_offset,
                     got.payload_offset);
            if (got.status !== exp_w.status)
              $error("status expected %0d got %0d", exp_w.status, got.status);
            if (got.block_order !== exp_w.block_order)
              $error("block_order expected %0d got %0d", exp_w.block_order,
                     got.block_order);
            if (got.free_bytes !== exp_w.free_bytes)
              $error("free_bytes expected %0d got %0d", exp_w.free_bytes,
                     got.free_bytes);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        pool_log = (cfg_data < 7) ? 7 : (cfg_data > MAX_ORD) ? MAX_ORD : int'(cfg_data);
        reset_pool();
      end
      if (s_tvalid && s_tready)
        predict_word(s_tuser, s_tdata[15:0], s_tdata[31:16]);
    end
    pending <= expected_words.size();
  end
endmodule

FILE: bench/power_of_two_block_allocator_tb.sv
// Testbench top for the power-of-two block allocator: drives commands and pool_order
// writes, varies back pressure, and reports the verdict from the checker's failure count.
// Depends on p2ba_pkg, p2ba_checker and power_of_two_block_allocator.
`timescale 1ns / 1ps
module power_of_two_block_allocator_tb;
  import p2ba_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;  // request_size [15:0], address [31:16]
  logic        s_tuser;  // command
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;  // payload_offset, status, block_order, free_bytes
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  int fail_count;
  int pending;
  int cycles;

  // Percent of cycles in which each side holds back.
  int send_idle;
  int recv_idle;
  // One long receiver stall is requested by the stimulus and counted by the receiver.
  logic hold_req;
  logic hold_done;
  int   hold_left;

  int cur_pool;
  // Payload offsets from granted allocations that have not been freed yet.
  logic [15:0] live_addrs[$];
  logic [15:0] freed_addrs[$];

  power_of_two_block_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  p2ba_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[power_of_two_block_allocator] ERROR");
      $finish;
    end
  end

  // Receiver: random back pressure, plus one long stall so that the block fills
  // its output register and then stops taking command words.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Granted allocations feed the pool of well-formed frees.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready && m_tdata[17:16] == STATUS_OK && m_tdata[15:0] != 0)
      live_addrs.push_back(m_tdata[15:0]);
  end

  // Offers one command word and returns on the falling edge after it was taken.
  task automatic send_word(input logic cmd, input logic [15:0] size, input logic [15:0] addr);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {addr, size};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Only written with the pipeline empty; the pool is rebuilt, so stale offsets go.
  task automatic write_pool(input logic [4:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_pool = (value < 7) ? 7 : (value > 16) ? 16 : int'(value);
    live_addrs.delete();
    freed_addrs.delete();
  endtask

  // Mostly allocations sized to the pool and frees of live blocks; the rest are
  // oversize requests and frees of null, misaligned, stale or random offsets.
  task automatic random_word();
    int r, k;
    logic [15:0] size, addr;
    r = $urandom_range(0, 99);
    size = 16'($urandom());
    addr = 16'($urandom());
    if (r < 45) begin
      k = $urandom_range(0, 99);
      if (k < 85) size = 16'($urandom_range(0, (1 << cur_pool) / 16));
      else if (k < 95) size = 16'($urandom_range(0, 1 << cur_pool));
      send_word(CMD_ALLOC, size, addr);
    end else if (r < 85 && live_addrs.size() != 0) begin
      k = $urandom_range(0, live_addrs.size() - 1);
      addr = live_addrs[k];
      live_addrs.delete(k);
      freed_addrs.push_back(addr);
      send_word(CMD_FREE, size, addr);
    end else begin
      k = $urandom_range(0, 5);
      if (k == 0) addr = 16'd0;
      else if (k == 1 && freed_addrs.size() != 0)
        addr = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
      else if (k == 2) addr = 16'($urandom_range(0, 1023) * 64 + 16);
      else if (k == 3) addr = addr | 16'd1;
      send_word(CMD_FREE, size, addr);
    end
  endtask

  initial begin
    logic [4:0] pools[6];
    pools = '{5'd0, 5'd12, 5'd31, 5'd9, 5'd7, 5'd16};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_ALLOC;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    cycles    = 0;
    send_idle = 20;
    recv_idle = 71;
    cur_pool  = 16;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words on the full 64 KiB pool after reset.
    send_word(CMD_ALLOC, 16'd65520, 16'd0);  // whole pool, order 16
    send_word(CMD_ALLOC, 16'd0, 16'hFFFF);   // nothing left on any list
    send_word(CMD_FREE, 16'hFFFF, 16'd16);   // give the whole pool back
    send_word(CMD_FREE, 16'd0, 16'd16);      // second free of the same block
    send_word(CMD_ALLOC, 16'd0, 16'd0);      // smallest block, full split
    send_word(CMD_ALLOC, 16'd48, 16'd0);     // exactly one granule with header
    send_word(CMD_ALLOC, 16'd49, 16'd0);     // one byte over, next order
    send_word(CMD_ALLOC, 16'hFFFF, 16'd0);   // larger than any pool
    send_word(CMD_FREE, 16'd0, 16'd0);       // null offset
    send_word(CMD_FREE, 16'd0, 16'd8);       // inside the header
    send_word(CMD_FREE, 16'd0, 16'd17);      // block start not aligned
    send_word(CMD_FREE, 16'd0, 16'hFFFF);    // top of the address range
    send_word(CMD_FREE, 16'd0, 16'd208);     // aligned, no live block
    send_word(CMD_FREE, 16'd0, 16'd80);
    send_word(CMD_ALLOC, 16'd32767, 16'd0);
    send_word(CMD_ALLOC, 16'd32752, 16'd0);
    write_pool(5'd7);
    live_addrs.delete();
    send_word(CMD_ALLOC, 16'd112, 16'd0);    // the whole small pool
    send_word(CMD_ALLOC, 16'd113, 16'd0);    // too big for this pool
    send_word(CMD_FREE, 16'd0, 16'd144);     // beyond the end of the pool
    send_word(CMD_FREE, 16'd0, 16'd16);

    // Random phases: two pool sizes per idling mode.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 71;
        recv_idle = 20;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_pool(pools[p]);
      for (int i = 0; i < 222; i++) begin
        if (p == 1 && i == 20) hold_req = 1'b1;
        if (i == 111) begin
          s_tvalid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        random_word();
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("[power_of_two_block_allocator] OK");
    end else begin
      $display("[power_of_two_block_allocator] ERROR");
    end
    $finish;
  end
endmodule
